// File: hdl/parking_distance_indicator_unit_macros.svh
// ----------------------------------------------------------------------------
// Parking distance indicator - assertion macros
// Shared property forms; clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PARKING_DISTANCE_INDICATOR_UNIT_MACROS_SVH
`define PARKING_DISTANCE_INDICATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PDI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PDI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/pdi_pkg.sv
// ----------------------------------------------------------------------------
// pdi_pkg
// Types and constants shared by the parking distance indicator modules.
// ----------------------------------------------------------------------------
package pdi_pkg;

	// Distance in 1/256 inch, two's complement
	typedef logic signed [16:0] dist_t;

	// Register map, one 32-bit word per register
	typedef enum logic [2:0] {
		REG_JUMP_LIMIT   = 3'd0,
		REG_MOVEMENT     = 3'd1,
		REG_IDLE_TIMEOUT = 3'd2,
		REG_STOP         = 3'd3,
		REG_CLOSE        = 3'd4,
		REG_NEAR         = 3'd5,
		REG_FAR          = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  jump_limit_in;
		logic [7:0]  movement_in;
		logic [15:0] idle_timeout_ms;
		logic [7:0]  stop_in;
		logic [7:0]  close_in;
		logic [7:0]  near_in;
		logic [7:0]  far_in;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		jump_limit_in:   8'd24,
		movement_in:     8'd3,
		idle_timeout_ms: 16'd10000,
		stop_in:         8'd6,
		close_in:        8'd12,
		near_in:         8'd36,
		far_in:          8'd72
	};

	// Echo width to distance: echo_us * 443 / 256 gives 1/256 inch
	localparam logic [8:0] DIST_SCALE   = 9'd443;
	localparam dist_t      DIST_TIMEOUT = -17'sd256;

	// Zone of a filtered distance
	typedef enum logic [2:0] {
		ZN_FLASH,
		ZN_RED,
		ZN_ORANGE,
		ZN_YELLOW,
		ZN_GREEN
	} zone_t;

	// One classified sample, front to back
	typedef struct packed {
		logic  idle;
		zone_t zone;
		dist_t filt;
	} job_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam rgb_t COL_BLACK  = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
	localparam rgb_t COL_RED    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
	localparam rgb_t COL_ORANGE = '{red: 8'd255, green: 8'd64,  blue: 8'd0};
	localparam rgb_t COL_YELLOW = '{red: 8'd255, green: 8'd200, blue: 8'd0};
	localparam rgb_t COL_GREEN  = '{red: 8'd0,   green: 8'd255, blue: 8'd0};

	localparam logic [9:0] HOLD_STEADY    = 10'd100;
	localparam logic [9:0] HOLD_FLASH_ON  = 10'd500;
	localparam logic [9:0] HOLD_FLASH_OFF = 10'd600;

	// One strip command leaving the block
	typedef struct packed {
		rgb_t       color;
		logic       refresh;
		logic [9:0] hold_ms;
		dist_t      filtered_q8;
		logic       last;
	} cmd_t;

	// Command sequencer phase
	typedef enum logic {
		BK_FIRST,
		BK_SECOND
	} back_state_t;

endpackage

// File: hdl/parking_distance_indicator_unit.sv
// ----------------------------------------------------------------------------
// parking_distance_indicator_unit
// Ultrasonic echo to LED strip command converter with register port.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one sample per request, echo width in microseconds
//   and a millisecond timestamp. Output stream (m_*): strip commands, one or
//   two per sample (none for a sample taken while the strip is already off
//   after the idle timeout); tlast marks the final command of a sample.
//   The user writes registers through the APB-style port only while the block
//   is idle; the block itself does not enforce this.
// Path: two classify stages, the job queue, then the output register.
// Throughput: the front takes one sample per cycle while s_tready is high; the
//   sequencer gives one command per cycle while the output can load, so a
//   flashing-red sample takes two commands and all others at most one. The job
//   queue (QUEUE_DEPTH entries, at least 2) sets how far the front may run ahead.
// Reset: registers take their defaults, the strip counts as lit with black
//   shown, kept distance and activity time are zero. No clearing pass.
// Stall: while m_tready is low the command waits in the output register, the
//   queue fills and s_tready drops once it has no room for samples in the pipe.
// ----------------------------------------------------------------------------
module parking_distance_indicator_unit import pdi_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // echo_us[14:0], now_ms[46:15], zero pad
	// command output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // red[7:0], green[15:8], blue[23:16],
	                              // hold_ms[33:24], filtered_q8[50:34], zero pad
	output logic        m_tuser,  // refresh
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cfg_t          cfg_q;
	reg_idx_t      reg_idx;
	logic          wr_en;
	logic          push;
	job_t          push_job;
	logic          pop;
	logic          head_valid;
	job_t          head_job;
	logic [CW-1:0] q_count;
	cmd_t          cmd;

	// Register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_JUMP_LIMIT:   cfg_q.jump_limit_in   <= pwdata[7:0];
				REG_MOVEMENT:     cfg_q.movement_in     <= pwdata[7:0];
				REG_IDLE_TIMEOUT: cfg_q.idle_timeout_ms <= pwdata[15:0];
				REG_STOP:         cfg_q.stop_in         <= pwdata[7:0];
				REG_CLOSE:        cfg_q.close_in        <= pwdata[7:0];
				REG_NEAR:         cfg_q.near_in         <= pwdata[7:0];
				REG_FAR:          cfg_q.far_in          <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_JUMP_LIMIT:   prdata = {24'd0, cfg_q.jump_limit_in};
			REG_MOVEMENT:     prdata = {24'd0, cfg_q.movement_in};
			REG_IDLE_TIMEOUT: prdata = {16'd0, cfg_q.idle_timeout_ms};
			REG_STOP:         prdata = {24'd0, cfg_q.stop_in};
			REG_CLOSE:        prdata = {24'd0, cfg_q.close_in};
			REG_NEAR:         prdata = {24'd0, cfg_q.near_in};
			REG_FAR:          prdata = {24'd0, cfg_q.far_in};
			default:          prdata = 32'd0;
		endcase
	end

	pdi_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_echo_us (s_tdata[14:0]),
		.in_now_ms  (s_tdata[46:15]),
		.cfg        (cfg_q),
		.q_count    (q_count),
		.push       (push),
		.push_job   (push_job)
	);

	pdi_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.count      (q_count)
	);

	pdi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_cmd    (cmd)
	);

	// Output packing
	assign m_tdata = {5'd0, cmd.filtered_q8, cmd.hold_ms,
	                  cmd.color.blue, cmd.color.green, cmd.color.red};
	assign m_tuser = cmd.refresh;
	assign m_tlast = cmd.last;

endmodule

// File: hdl/pdi_front.sv
// ----------------------------------------------------------------------------
// pdi_front
// Converts echo width to distance, filters jumps, tracks activity and
// classifies each sample into a job for the command sequencer.
// ----------------------------------------------------------------------------
module pdi_front import pdi_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [14:0]                      in_echo_us,
	input  logic [31:0]                      in_now_ms,
	input  cfg_t                             cfg,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
	output logic                             push,
	output job_t                             push_job
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic        accept;
	logic [23:0] prod;
	dist_t       dist_in;

	logic        v_s1_q;
	dist_t       dist_s1;
	logic [31:0] now_s1;

	dist_t       kept_q;
	logic [31:0] active_q;

	logic signed [17:0] diff;
	logic        [17:0] diff_abs;
	logic               reject;
	logic               moved;
	dist_t              filt;
	logic [31:0]        active_new;

	logic        v_s2_q;
	dist_t       filt_s2;
	logic [31:0] now_s2;
	logic [31:0] active_s2;
	logic [31:0] elapsed;
	logic [CW:0] in_flight;

	// Credit check: room in the queue for everything already in the pipe
	assign in_flight = (CW+1)'(q_count) + (CW+1)'(v_s1_q) + (CW+1)'(v_s2_q);
	assign in_ready  = in_flight < (CW+1)'(QUEUE_DEPTH);
	assign accept    = in_valid && in_ready;

	// Echo to distance
	assign prod    = 24'(in_echo_us) * 24'(DIST_SCALE);
	assign dist_in = (in_echo_us == 15'd0) ? DIST_TIMEOUT : dist_t'({1'b0, prod[23:8]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else begin
			v_s1_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dist_s1 <= dist_in;
			now_s1  <= in_now_ms;
		end
	end

	// Jump filter and movement detect
	always_comb begin
		diff       = 18'(dist_s1) - 18'(kept_q);
		diff_abs   = (diff < 0) ? 18'(-diff) : 18'(diff);
		reject     = (diff_abs > {2'b00, cfg.jump_limit_in, 8'd0}) &&
		             (18'(dist_s1) > $signed({2'b00, cfg.far_in, 8'd0}));
		moved      = diff_abs > {2'b00, cfg.movement_in, 8'd0};
		filt       = reject ? kept_q : dist_s1;
		active_new = (!reject && moved) ? now_s1 : active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q   <= '0;
			active_q <= '0;
			v_s2_q   <= 1'b0;
		end else begin
			v_s2_q <= v_s1_q;
			if (v_s1_q) begin
				kept_q   <= filt;
				active_q <= active_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1_q) begin
			filt_s2   <= filt;
			now_s2    <= now_s1;
			active_s2 <= active_new;
		end
	end

	// Idle timeout and zone classification
	assign elapsed = now_s2 - active_s2;

	always_comb begin
		push_job.idle = elapsed > {16'd0, cfg.idle_timeout_ms};
		push_job.filt = filt_s2;
		if (filt_s2 < $signed({1'b0, cfg.stop_in, 8'd0})) begin
			push_job.zone = ZN_FLASH;
		end else if (filt_s2 < $signed({1'b0, cfg.close_in, 8'd0})) begin
			push_job.zone = ZN_RED;
		end else if (filt_s2 < $signed({1'b0, cfg.near_in, 8'd0})) begin
			push_job.zone = ZN_ORANGE;
		end else if (filt_s2 < $signed({1'b0, cfg.far_in, 8'd0})) begin
			push_job.zone = ZN_YELLOW;
		end else begin
			push_job.zone = ZN_GREEN;
		end
	end

	assign push = v_s2_q;

endmodule

// File: hdl/pdi_queue.sv
// ----------------------------------------------------------------------------
// pdi_queue
// Short job FIFO between classifier and command sequencer.
// ----------------------------------------------------------------------------
`include "parking_distance_indicator_unit_macros.svh"

module pdi_queue import pdi_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  job_t                             push_job,
	input  logic                             pop,
	output logic                             head_valid,
	output job_t                             head_job,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	// Entry store
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign head_valid = count_q != '0;
	assign head_job   = entry_q[rd_ptr_q];
	assign count      = count_q;

	`PDI_ASSERT_SAME(a_no_push_full, count_q == CW'(QUEUE_DEPTH), !push, "job queue overrun")
	`PDI_ASSERT_SAME(a_no_pop_empty, count_q == '0, !pop, "job queue underrun")

endmodule

// File: hdl/pdi_back.sv
// ----------------------------------------------------------------------------
// pdi_back
// Command sequencer: turns jobs into strip commands, tracks the shown colour
// and whether the strip is lit, and holds the output register.
// ----------------------------------------------------------------------------
`include "parking_distance_indicator_unit_macros.svh"

module pdi_back import pdi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  job_t head_job,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	back_state_t state_q;
	back_state_t state_d;

	logic       load_ok;
	logic       emit;
	logic       strip_off;
	rgb_t       cmd_color;
	logic [9:0] cmd_hold;
	logic       cmd_last;
	logic       refresh;

	logic       lit_q;
	rgb_t       shown_q;
	logic       out_valid_q;
	cmd_t       out_cmd_q;

	assign load_ok = !out_valid_q || out_ready;

	// Next phase
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_FIRST: begin
				if (head_valid && !head_job.idle && head_job.zone == ZN_FLASH && load_ok) begin
					state_d = BK_SECOND;
				end
			end
			BK_SECOND: begin
				if (load_ok) begin
					state_d = BK_FIRST;
				end
			end
			default: state_d = BK_FIRST;
		endcase
	end

	// Command selection
	always_comb begin
		emit      = 1'b0;
		pop       = 1'b0;
		strip_off = 1'b0;
		cmd_color = COL_BLACK;
		cmd_hold  = HOLD_STEADY;
		cmd_last  = 1'b1;
		case (state_q)
			BK_FIRST: begin
				if (head_valid) begin
					if (head_job.idle) begin
						// idle: one switch-off command while lit, else nothing
						if (lit_q) begin
							emit      = load_ok;
							pop       = load_ok;
							strip_off = 1'b1;
						end else begin
							pop = 1'b1;
						end
					end else begin
						emit = load_ok;
						pop  = load_ok;
						case (head_job.zone)
							ZN_FLASH: begin
								cmd_color = COL_RED;
								cmd_hold  = HOLD_FLASH_ON;
								cmd_last  = 1'b0;
								pop       = 1'b0;
							end
							ZN_RED:    cmd_color = COL_RED;
							ZN_ORANGE: cmd_color = COL_ORANGE;
							ZN_YELLOW: cmd_color = COL_YELLOW;
							ZN_GREEN:  cmd_color = COL_GREEN;
							default:   cmd_color = COL_GREEN;
						endcase
					end
				end
			end
			BK_SECOND: begin
				// off half of the flash
				emit     = load_ok;
				pop      = load_ok;
				cmd_hold = HOLD_FLASH_OFF;
			end
			default: ;
		endcase
	end

	assign refresh = cmd_color != shown_q;

	// Phase, strip state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_FIRST;
			lit_q       <= 1'b1;
			shown_q     <= COL_BLACK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				shown_q <= cmd_color;
				if (strip_off) begin
					lit_q <= 1'b0;
				end else if (refresh) begin
					lit_q <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_cmd_q.color       <= cmd_color;
			out_cmd_q.refresh     <= refresh;
			out_cmd_q.hold_ms     <= cmd_hold;
			out_cmd_q.filtered_q8 <= head_job.filt;
			out_cmd_q.last        <= cmd_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_cmd   = out_cmd_q;

	`PDI_ASSERT_SAME(a_second_needs_flash, state_q == BK_SECOND,
		head_valid && !head_job.idle && head_job.zone == ZN_FLASH,
		"flash off phase without a flashing job at the head")
	`PDI_ASSERT_SAME(a_not_last_is_flash_on, out_valid_q && !out_cmd_q.last,
		out_cmd_q.hold_ms == HOLD_FLASH_ON && out_cmd_q.color == COL_RED,
		"non-final command other than flash on")

endmodule
